// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DepthDefault = 16;
  localparam int ValueW = 32;
  localparam int PrioW = 16;
  localparam int CountOutW = 5;

  // request operations; the unused code behaves as a peek
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // result status
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic signed [ValueW-1:0] item_value;
    logic signed [PrioW-1:0] item_priority;
  } req_t;

  typedef struct packed {
    logic signed [ValueW-1:0] head_value;
    logic signed [PrioW-1:0] head_priority;
    logic [1:0] status;
    logic [CountOutW-1:0] entry_count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
    logic signed [ValueW-1:0] new_value;
    logic signed [PrioW-1:0] new_priority;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell (
  input  logic clk,
  input  logic rst,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic left_keep,
  input  logic left_valid,
  input  logic signed [spq_pkg::ValueW-1:0] left_value,
  input  logic signed [spq_pkg::PrioW-1:0] left_priority,
  input  logic right_valid,
  input  logic signed [spq_pkg::ValueW-1:0] right_value,
  input  logic signed [spq_pkg::PrioW-1:0] right_priority,
  output logic keep,
  output logic valid,
  output logic signed [spq_pkg::ValueW-1:0] value,
  output logic signed [spq_pkg::PrioW-1:0] prio
);

  // entry stays put when it ranks at or above the new one
  assign keep = valid && (prio >= ctrl.new_priority);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.push && !keep) begin
      valid <= left_keep ? 1'b1 : left_valid;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !keep) begin
      if (left_keep) begin
        value <= ctrl.new_value;
        prio <= ctrl.new_priority;
      end else begin
        value <= left_value;
        prio <= left_priority;
      end
    end else if (ctrl.pop) begin
      value <= right_value;
      prio <= right_priority;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// sorted priority queue built as a row of compare-and-shift cells
// req channel: one beat per request (push, pop, peek); accepted when
//   req_valid is high and req_stall is low
// rsp channel: exactly one beat per request, in request order, carrying
//   head value and priority (pop and peek), a status and the entry count
// cells are kept ordered by priority, highest at cell 0; equal priorities
//   keep arrival order since a push lands behind every entry ranked >= it
// the response is registered, valid in the cycle after acceptance
// throughput: one request per cycle while req_stall is low; every cell
//   compares and shifts in the same cycle, so the row update is the whole cost of a request
// a push into a full queue is dropped with status full; pop or peek on an
//   empty queue reports status empty and zero head fields
// reset empties the row (valid bits and count cleared), no sweep needed
// receiver stall: the response register holds its beat, and req_stall
//   rises while that beat waits, so requests back up without loss
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  spq_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output spq_pkg::rsp_t rsp
);

  localparam int CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic req_take;
  logic is_push;
  logic is_pop;
  logic full;
  logic empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::rsp_t rsp_next;
  logic [CountW+spq_pkg::CountOutW-1:0] count_wide;

  // cell row wiring
  logic [DEPTH-1:0] keep_vec;
  logic [DEPTH-1:0] valid_vec;
  logic signed [spq_pkg::ValueW-1:0] value_arr [DEPTH];
  logic signed [spq_pkg::PrioW-1:0] prio_arr [DEPTH];

  // a waiting response blocks new requests
  assign req_stall = rsp_valid && rsp_stall;
  assign req_take = req_valid && !req_stall;

  assign is_push = (req.op == spq_pkg::OP_PUSH);
  assign is_pop = (req.op == spq_pkg::OP_POP);
  assign full = (count == CountW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctrl.push = req_take && is_push && !full;
    ctrl.pop = req_take && is_pop && !empty;
    ctrl.new_value = req.item_value;
    ctrl.new_priority = req.item_priority;
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  // entry count wraps to the output field width
  assign count_wide = {{spq_pkg::CountOutW{1'b0}}, count_next};

  always_comb begin
    rsp_next.head_value = '0;
    rsp_next.head_priority = '0;
    rsp_next.status = spq_pkg::ST_OK;
    rsp_next.entry_count = count_wide[spq_pkg::CountOutW-1:0];
    if (is_push) begin
      if (full) begin
        rsp_next.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      rsp_next.status = spq_pkg::ST_EMPTY;
    end else begin
      // head lives in cell 0
      rsp_next.head_value = value_arr[0];
      rsp_next.head_priority = prio_arr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_take) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      rsp <= rsp_next;
    end
  end

  // row of cells: cell 0 has no left neighbor, the last has no right one
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic l_keep;
      logic l_valid;
      logic signed [spq_pkg::ValueW-1:0] l_value;
      logic signed [spq_pkg::PrioW-1:0] l_prio;
      logic r_valid;
      logic signed [spq_pkg::ValueW-1:0] r_value;
      logic signed [spq_pkg::PrioW-1:0] r_prio;

      if (i == 0) begin : g_first
        assign l_keep = 1'b1;
        assign l_valid = 1'b0;
        assign l_value = '0;
        assign l_prio = '0;
      end else begin : g_mid
        assign l_keep = keep_vec[i-1];
        assign l_valid = valid_vec[i-1];
        assign l_value = value_arr[i-1];
        assign l_prio = prio_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_value = '0;
        assign r_prio = '0;
      end else begin : g_inner
        assign r_valid = valid_vec[i+1];
        assign r_value = value_arr[i+1];
        assign r_prio = prio_arr[i+1];
      end

      spq_cell u_cell (
        .clk(clk),
        .rst(rst),
        .ctrl(ctrl),
        .left_keep(l_keep),
        .left_valid(l_valid),
        .left_value(l_value),
        .left_priority(l_prio),
        .right_valid(r_valid),
        .right_value(r_value),
        .right_priority(r_prio),
        .keep(keep_vec[i]),
        .valid(valid_vec[i]),
        .value(value_arr[i]),
        .prio(prio_arr[i])
      );
    end
  endgenerate

  // occupied cells match the entry count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("cell valid bits disagree with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(DEPTH))
    else $error("entry count beyond depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    req_take && is_pop && !empty |=> count == $past(count) - 1'b1)
    else $error("pop did not remove an entry");

  a_full_push_drops: assert property (@(posedge clk) disable iff (rst)
    req_take && is_push && full |=> $stable(count) && rsp.status == spq_pkg::ST_FULL)
    else $error("push into full queue not dropped");

  a_rsp_follows_req: assert property (@(posedge clk) disable iff (rst)
    req_take |=> rsp_valid)
    else $error("accepted request produced no response");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int QueueDepth = spq_pkg::DepthDefault;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomItems = 450;
  localparam int CalmTail = 60;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 8;

  typedef struct {
    spq_pkg::req_t r;
    int reps;
    bit typed;
    spq_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  spq_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  spq_pkg::rsp_t rsp;

  // expectation attached to the beat on the request bus
  logic cur_typed;
  spq_pkg::rsp_t cur_want;

  // shadow of the queue contents
  logic signed [spq_pkg::ValueW-1:0] held_values [QueueDepth];
  logic signed [spq_pkg::PrioW-1:0] held_prios [QueueDepth];
  int held_count;

  spq_pkg::rsp_t pending_rsp [$];
  dir_row_t dir_rows [$];
  int errors;
  int cycles;
  bit idle_on;
  bit calm;

  sorted_priority_queue #(
    .DEPTH(QueueDepth)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  // one request against the shadow queue: new entries go behind every
  // entry of greater or equal priority, pop and peek read slot 0
  task automatic serve_request(input spq_pkg::req_t r, output spq_pkg::rsp_t o);
    int pos;
    int i;
    o = '0;
    if (r.op == spq_pkg::OP_PUSH) begin
      if (held_count >= QueueDepth) begin
        o.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prios[pos] >= r.item_priority) pos++;
        for (i = held_count; i > pos; i--) begin
          held_values[i] = held_values[i-1];
          held_prios[i] = held_prios[i-1];
        end
        held_values[pos] = r.item_value;
        held_prios[pos] = r.item_priority;
        held_count++;
      end
    end else if (held_count == 0) begin
      o.status = spq_pkg::ST_EMPTY;
    end else begin
      o.head_value = held_values[0];
      o.head_priority = held_prios[0];
      if (r.op == spq_pkg::OP_POP) begin
        for (i = 0; i + 1 < held_count; i++) begin
          held_values[i] = held_values[i+1];
          held_prios[i] = held_prios[i+1];
        end
        held_count--;
      end
    end
    o.entry_count = 5'(held_count);
  endtask

  // request side first, so a same-edge response would still find its entry
  always @(posedge clk) begin
    spq_pkg::rsp_t pred;
    spq_pkg::rsp_t got_want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        serve_request(req, pred);
        pending_rsp.insert(pending_rsp.size(), cur_typed ? cur_want : pred);
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %h", rsp));
        end else begin
          got_want = pending_rsp.pop_front();
          if (rsp.head_value !== got_want.head_value)
            report_mismatch($sformatf("head_value %h, expected %h",
              rsp.head_value, got_want.head_value));
          if (rsp.head_priority !== got_want.head_priority)
            report_mismatch($sformatf("head_priority %h, expected %h",
              rsp.head_priority, got_want.head_priority));
          if (rsp.status !== got_want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
              rsp.status, got_want.status));
          if (rsp.entry_count !== got_want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
              rsp.entry_count, got_want.entry_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
        pending_rsp.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: stall bursts mixed with quiet stretches, none in the tail
  initial begin
    rsp_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (calm || $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic add_row(input logic [1:0] op, input logic [31:0] val,
                         input logic [15:0] pri, input int reps, input bit typed,
                         input logic [31:0] hv, input logic [15:0] hp,
                         input logic [1:0] st, input logic [4:0] cnt);
    dir_row_t row;
    row.r.op = op;
    row.r.item_value = val;
    row.r.item_priority = pri;
    row.reps = reps;
    row.typed = typed;
    row.want.head_value = hv;
    row.want.head_priority = hp;
    row.want.status = st;
    row.want.entry_count = cnt;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // drive one request beat and hold it until the block takes it
  task automatic send_request(input spq_pkg::req_t r, input bit typed,
                              input spq_pkg::rsp_t want);
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    cur_typed <= typed;
    cur_want <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_priority();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'($signed($urandom_range(0, 4)) - 2);
    if (roll < 52) return 16'h7fff;
    if (roll < 60) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic spq_pkg::req_t make_request(input int push_pct);
    spq_pkg::req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) r.op = spq_pkg::OP_PUSH;
    else begin
      roll = $urandom_range(0, 99);
      r.op = (roll < 60) ? spq_pkg::OP_POP : (roll < 85) ? spq_pkg::OP_PEEK : OpUnused;
    end
    case ($urandom_range(0, 19))
      0: r.item_value = 32'h7fffffff;
      1: r.item_value = 32'h80000000;
      2: r.item_value = 32'hffffffff;
      default: r.item_value = $urandom;
    endcase
    r.item_priority = pick_priority();
    return r;
  endfunction

  initial begin
    spq_pkg::req_t r;
    spq_pkg::rsp_t none;
    int push_pct;
    int phase_left;
    int k;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cur_typed <= 1'b0;
    cur_want <= '0;
    none = '0;
    errors = 0;
    cycles = 0;
    held_count = 0;
    idle_on = 1'b1;
    calm = 1'b0;

    // empty queue, extremes, tie order, op code 3, filling and overflow
    add_row(spq_pkg::OP_PEEK, 32'h0, 16'h0, 1, 1, 32'h0, 16'h0, spq_pkg::ST_EMPTY, 5'd0);
    add_row(spq_pkg::OP_POP, 32'h1234, 16'h55, 1, 1, 32'h0, 16'h0, spq_pkg::ST_EMPTY, 5'd0);
    add_row(OpUnused, 32'h0, 16'h0, 1, 1, 32'h0, 16'h0, spq_pkg::ST_EMPTY, 5'd0);
    add_row(spq_pkg::OP_PUSH, 32'h7fffffff, 16'h7fff, 1, 1, 32'h0, 16'h0,
            spq_pkg::ST_OK, 5'd1);
    add_row(spq_pkg::OP_PEEK, 32'h0, 16'h0, 1, 1, 32'h7fffffff, 16'h7fff,
            spq_pkg::ST_OK, 5'd1);
    add_row(spq_pkg::OP_POP, 32'h0, 16'h0, 1, 1, 32'h7fffffff, 16'h7fff,
            spq_pkg::ST_OK, 5'd0);
    add_row(spq_pkg::OP_PUSH, 32'h80000000, 16'h8000, 1, 1, 32'h0, 16'h0,
            spq_pkg::ST_OK, 5'd1);
    add_row(spq_pkg::OP_PUSH, 32'h1, 16'h8000, 1, 1, 32'h0, 16'h0, spq_pkg::ST_OK, 5'd2);
    add_row(spq_pkg::OP_PUSH, 32'h2, 16'h0, 1, 1, 32'h0, 16'h0, spq_pkg::ST_OK, 5'd3);
    add_row(spq_pkg::OP_POP, 32'h0, 16'h0, 1, 1, 32'h2, 16'h0, spq_pkg::ST_OK, 5'd2);
    add_row(spq_pkg::OP_POP, 32'h0, 16'h0, 1, 1, 32'h80000000, 16'h8000,
            spq_pkg::ST_OK, 5'd1);
    add_row(OpUnused, 32'h0, 16'h0, 1, 1, 32'h1, 16'h8000, spq_pkg::ST_OK, 5'd1);
    add_row(spq_pkg::OP_POP, 32'h0, 16'h0, 1, 1, 32'h1, 16'h8000, spq_pkg::ST_OK, 5'd0);
    add_row(spq_pkg::OP_PUSH, 32'h100, 16'h3, QueueDepth, 0, 32'h0, 16'h0,
            spq_pkg::ST_OK, 5'd0);
    add_row(spq_pkg::OP_PUSH, 32'hffffffff, 16'h7fff, 1, 1, 32'h0, 16'h0,
            spq_pkg::ST_FULL, 5'd16);
    add_row(spq_pkg::OP_POP, 32'h0, 16'h0, 1, 0, 32'h0, 16'h0, spq_pkg::ST_OK, 5'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n]) begin
      for (k = 0; k < dir_rows[n].reps; k++) begin
        r = dir_rows[n].r;
        // repeated pushes walk values and cycle through a few priorities
        r.item_value = r.item_value + k;
        r.item_priority = 16'(r.item_priority + (k % 4));
        send_request(r, dir_rows[n].typed, dir_rows[n].want);
      end
    end

    // random phases: filling, draining and churning around a mid level
    push_pct = 50;
    phase_left = 0;
    for (k = 0; k < RandomItems; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (k == RandomItems - CalmTail) calm = 1'b1;
      send_request(make_request(push_pct), 1'b0, none);
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
